// ----- hdl/cmisp_pkg.sv -----
`timescale 1ns / 1ps

package cmisp_pkg;

   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned DATA_W     = 8;
   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned BANK_W     = 6;
   localparam int unsigned BANK_N     = 4;
   localparam int unsigned SEL_W      = 2;
   localparam int unsigned ROM_ADDR_W = 32;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

   localparam logic [SEL_W-1:0] SEL_NONE   = 2'd0;
   localparam logic [SEL_W-1:0] SEL_PRG    = 2'd1;
   localparam logic [SEL_W-1:0] SEL_SPEECH = 2'd2;
   localparam logic [SEL_W-1:0] SEL_FF     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_READ_FILTER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_PRESENT = 1'd1;

   localparam logic [7:0] FILTER_RESET  = 8'd2;
   localparam logic       PRESENT_RESET = 1'b1;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ADDR_W-1:0]  address;
      logic [DATA_W-1:0]  data;
      logic [STAMP_W-1:0] cycle_stamp;
   } item_type;

   typedef struct packed {
      logic                  irq_line;
      logic [BANK_W-1:0]     prg_bank_low;
      logic [BANK_W-1:0]     prg_bank_high;
      logic [BANK_W-1:0]     chr_bank_low;
      logic [SEL_W-1:0]      rom_select;
      logic [ROM_ADDR_W-1:0] rom_address;
   } result_type;

   typedef struct packed {
      logic [BANK_N-1:0][BANK_W-1:0] bank_regs;
      logic [7:0]                    irq_reload;
      logic [7:0]                    irq_counter;
      logic                          irq_enable;
      logic                          irq_pending;
      logic [31:0]                   speech_address;
      logic [7:0]                    speech_control;
      logic [STAMP_W-1:0]            last_read_cycle;
   } state_type;

   typedef struct packed {
      logic [7:0] read_filter_cycles;
      logic       speech_rom_present;
   } config_type;

endpackage

// ----- hdl/cmisp_exec.sv -----
`timescale 1ns / 1ps

module cmisp_exec (
   input  cmisp_pkg::item_type   item,
   input  cmisp_pkg::state_type  state,
   input  cmisp_pkg::config_type cfg,
   output cmisp_pkg::state_type  state_next,
   output cmisp_pkg::result_type result
);

   logic [cmisp_pkg::ADDR_W-1:0] a;
   logic                         speech_hit;
   logic                         new_access;
   logic [cmisp_pkg::STAMP_W:0]  limit;
   logic [7:0]                   cnt_next;
   logic [cmisp_pkg::BANK_W-1:0] bank;

   assign a     = item.address;
   assign limit = {1'b0, state.last_read_cycle}
                + {{(cmisp_pkg::STAMP_W - 7){1'b0}}, cfg.read_filter_cycles};
   assign new_access = (item.cycle_stamp < state.last_read_cycle)
                     || ({1'b0, item.cycle_stamp} > limit);
   assign speech_hit = (a[15:11] == 5'b01001) || (a[15:12] == 4'hC);
   assign cnt_next   = (state.irq_counter == 8'd0) ? state.irq_reload
                                                    : state.irq_counter - 8'd1;

   always_comb begin
      bank = state.bank_regs[0];
      unique case (a[15:13])
         3'd4:    bank = state.bank_regs[1];
         3'd5:    bank = state.bank_regs[2];
         default: bank = state.bank_regs[0];
      endcase
   end

   always_comb begin
      state_next        = state;
      result.rom_select  = cmisp_pkg::SEL_NONE;
      result.rom_address = '0;
      unique case (item.func)
         cmisp_pkg::FUNC_WRITE: begin
            if (a[15]) begin
               unique case (a[14:12])
                  3'd0: state_next.irq_reload = item.data;
                  3'd1: state_next.irq_counter = 8'd0;
                  3'd2, 3'd3: begin
                     state_next.irq_enable = a[12];
                     if (!a[12]) begin
                        state_next.irq_pending = 1'b0;
                     end
                  end
                  3'd4: state_next.speech_address = {state.speech_address[30:0],
                                                     item.data[7]};
                  3'd5: state_next.speech_control = item.data;
                  default: state_next.bank_regs[item.data[7:6]] = item.data[5:0];
               endcase
            end
         end
         cmisp_pkg::FUNC_READ: begin
            if (speech_hit) begin
               if (!cfg.speech_rom_present) begin
                  result.rom_select = cmisp_pkg::SEL_FF;
               end else begin
                  result.rom_select  = cmisp_pkg::SEL_SPEECH;
                  result.rom_address = state.speech_address;
                  if (new_access) begin
                     if (state.speech_control[1]) begin
                        state_next.speech_address = state.speech_address + 32'd1;
                     end
                     state_next.last_read_cycle = item.cycle_stamp;
                  end
               end
            end else if (a[15:12] == 4'h5) begin
               result.rom_select  = cmisp_pkg::SEL_PRG;
               result.rom_address = {19'd0, 1'b1, a[11:0]};
            end else if ((a[15:13] == 3'd3) || (a[15:13] == 3'd4) || (a[15:13] == 3'd5)) begin
               result.rom_select  = cmisp_pkg::SEL_PRG;
               result.rom_address = {13'd0, bank, a[12:0]};
            end
         end
         cmisp_pkg::FUNC_TICK: begin
            state_next.irq_counter = cnt_next;
            if (state.irq_enable && (cnt_next == 8'd0)) begin
               state_next.irq_pending = 1'b1;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
      result.irq_line      = state_next.irq_pending;
      result.prg_bank_low  = state_next.bank_regs[1];
      result.prg_bank_high = state_next.bank_regs[2];
      result.chr_bank_low  = state_next.bank_regs[3];
   end

endmodule

// ----- hdl/cartridge_mapper_irq_speech_port_unit.sv -----
`timescale 1ns / 1ps
// A word accepted on req_ is registered in the input stage, then written into the
// result queue when it has room, and rsp_ offers it from the queue.
// Throughput: one word per cycle; the decode and state update sit between the
// input stage register and a two-word result queue, so input stalls only when
// both queue entries are full and the held word cannot move on.
// Reset: synchronous, active high; clears all mapper state, sets read_filter_cycles
// to 2 and marks the speech ROM as fitted.

module cartridge_mapper_irq_speech_port_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // address[15:0], data[23:16], cycle_stamp[55:24]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // irq_line[0], prg_bank_low[6:1], prg_bank_high[12:7],
                                   // chr_bank_low[18:13], rom_address[50:19], zero[55:51]
   output logic [1:0]  rsp_tuser,  // rom_select[1:0]
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   cmisp_pkg::config_type cfg_ff;
   cmisp_pkg::state_type  state_ff, state_in;
   cmisp_pkg::item_type   stage_ff;
   logic                  stage_valid_ff;
   cmisp_pkg::result_type result;
   cmisp_pkg::result_type queue_ff [2];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            count_ff;
   logic                  push, pop, stage_fire;
   cmisp_pkg::result_type head;

   assign pop        = rsp_tvalid && rsp_tready;
   assign stage_fire = stage_valid_ff && ((count_ff != 2'd2) || pop);
   assign push       = stage_fire;
   assign req_tready = !stage_valid_ff || stage_fire;

   cmisp_exec u_exec (
      .item       (stage_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_filter_cycles <= cmisp_pkg::FILTER_RESET;
         cfg_ff.speech_rom_present <= cmisp_pkg::PRESENT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cmisp_pkg::CSR_READ_FILTER: cfg_ff.read_filter_cycles <= csr_data;
            cmisp_pkg::CSR_ROM_PRESENT: cfg_ff.speech_rom_present <= csr_data[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (stage_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff.func        <= req_tuser;
         stage_ff.address     <= req_tdata[15:0];
         stage_ff.data        <= req_tdata[23:16];
         stage_ff.cycle_stamp <= req_tdata[55:24];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         priority if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end else begin
            count_ff <= count_ff;
         end
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = head.rom_select;
   assign rsp_tdata  = {5'd0, head.rom_address, head.chr_bank_low,
                        head.prg_bank_high, head.prg_bank_low, head.irq_line};

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam logic [cmisp_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int PHASES = 5;
   localparam int HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 1000;

   class response_tracker;
      logic [cmisp_pkg::BANK_W-1:0] banks [cmisp_pkg::BANK_N];
      logic [7:0]                   irq_latch;
      logic [7:0]                   irq_count;
      logic                         irq_en;
      logic                         irq_pend;
      logic [31:0]                  speech_addr;
      logic [7:0]                   speech_ctrl;
      logic [31:0]                  last_stamp;
      logic [7:0]                   filter_window;
      logic                         rom_fitted;
      cmisp_pkg::result_type        expected_q[$];
      int                           errors;

      function new();
         foreach (banks[i]) banks[i] = '0;
         irq_latch = '0;
         irq_count = '0;
         irq_en = 1'b0;
         irq_pend = 1'b0;
         speech_addr = '0;
         speech_ctrl = '0;
         last_stamp = '0;
         filter_window = cmisp_pkg::FILTER_RESET;
         rom_fitted = cmisp_pkg::PRESENT_RESET;
         errors = 0;
      endfunction

      function void set_controls(logic [7:0] window, logic fitted);
         filter_window = window;
         rom_fitted = fitted;
      endfunction

      function void note_access(cmisp_pkg::item_type it);
         cmisp_pkg::result_type        r;
         logic [32:0]                  window_end;
         logic [cmisp_pkg::BANK_W-1:0] bank;
         logic [15:0]                  a;
         a = it.address;
         r = '0;
         case (it.func)
            cmisp_pkg::FUNC_WRITE: begin
               if (a[15]) begin
                  case (a[15:12])
                     4'h8: irq_latch = it.data;
                     4'h9: irq_count = '0;
                     4'hA, 4'hB: begin
                        irq_en = a[12];
                        if (!a[12]) irq_pend = 1'b0;
                     end
                     4'hC: speech_addr = {speech_addr[30:0], it.data[7]};
                     4'hD: speech_ctrl = it.data;
                     default: banks[it.data[7:6]] = it.data[5:0];
                  endcase
               end
            end
            cmisp_pkg::FUNC_READ: begin
               if ((a >= 16'h4800 && a <= 16'h4FFF) || a[15:12] == 4'hC) begin
                  if (!rom_fitted) begin
                     r.rom_select = cmisp_pkg::SEL_FF;
                  end else begin
                     r.rom_select = cmisp_pkg::SEL_SPEECH;
                     r.rom_address = speech_addr;
                     window_end = {1'b0, last_stamp} + {25'd0, filter_window};
                     if (it.cycle_stamp < last_stamp || {1'b0, it.cycle_stamp} > window_end) begin
                        if (speech_ctrl[1]) speech_addr = speech_addr + 32'd1;
                        last_stamp = it.cycle_stamp;
                     end
                  end
               end else if (a[15:12] == 4'h5) begin
                  r.rom_select = cmisp_pkg::SEL_PRG;
                  r.rom_address = 32'h1000 + {20'd0, a[11:0]};
               end else if (a >= 16'h6000 && a <= 16'hBFFF) begin
                  if (a < 16'h8000) bank = banks[0];
                  else if (a < 16'hA000) bank = banks[1];
                  else bank = banks[2];
                  r.rom_select = cmisp_pkg::SEL_PRG;
                  r.rom_address = {13'd0, bank, a[12:0]};
               end
            end
            cmisp_pkg::FUNC_TICK: begin
               if (irq_count == 8'd0) irq_count = irq_latch;
               else irq_count = irq_count - 8'd1;
               if (irq_en && irq_count == 8'd0) irq_pend = 1'b1;
            end
            default: ;
         endcase
         r.irq_line = irq_pend;
         r.prg_bank_low = banks[1];
         r.prg_bank_high = banks[2];
         r.chr_bank_low = banks[3];
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_response(cmisp_pkg::result_type got);
         cmisp_pkg::result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word, expected none, actual %0h", $time, got);
         end else begin
            want = expected_q.pop_front();
            compare_field("irq_line", 32'(want.irq_line), 32'(got.irq_line));
            compare_field("prg_bank_low", 32'(want.prg_bank_low), 32'(got.prg_bank_low));
            compare_field("prg_bank_high", 32'(want.prg_bank_high), 32'(got.prg_bank_high));
            compare_field("chr_bank_low", 32'(want.chr_bank_low), 32'(got.chr_bank_low));
            compare_field("rom_select", 32'(want.rom_select), 32'(got.rom_select));
            compare_field("rom_address", want.rom_address, got.rom_address);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [7:0]  csr_data;

   response_tracker tracker;
   logic [31:0]     stamp_clock;
   int              filter_now;
   bit              no_idle;
   bit              hold_request;
   int              quiet_cycles;

   cartridge_mapper_irq_speech_port_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic cmisp_pkg::item_type access(logic [cmisp_pkg::FUNC_W-1:0] f,
                                                  logic [15:0] a, logic [7:0] d,
                                                  logic [31:0] s);
      cmisp_pkg::item_type it;
      it.func = f;
      it.address = a;
      it.data = d;
      it.cycle_stamp = s;
      return it;
   endfunction

   function automatic cmisp_pkg::item_type random_access();
      cmisp_pkg::item_type it;
      int                  pick;
      int                  stamp_roll;
      it = access(FUNC_SPARE, 16'($urandom), 8'($urandom), $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         it.func = cmisp_pkg::FUNC_WRITE;
         if ($urandom_range(0, 9) != 0) it.address[15] = 1'b1;
         if ($urandom_range(0, 4) == 0) it.address[15:12] = 4'hC;
         if (it.address[15:12] == 4'h8 && $urandom_range(0, 3) != 0)
            it.data = 8'($urandom_range(0, 6));
      end else if (pick < 75) begin
         it.func = cmisp_pkg::FUNC_READ;
         case ($urandom_range(0, 5))
            0: it.address = {5'b01001, 11'($urandom)};
            1: it.address[15:12] = 4'hC;
            2: it.address[15:12] = 4'h5;
            3, 4: it.address[15:13] = 3'($urandom_range(3, 5));
            default: ;
         endcase
         stamp_roll = $urandom_range(0, 19);
         if (stamp_roll == 0) stamp_clock = $urandom;
         else if (stamp_roll == 1) stamp_clock = stamp_clock - 32'($urandom_range(1, 8));
         else stamp_clock = stamp_clock + 32'($urandom_range(0, filter_now + 3));
         it.cycle_stamp = stamp_clock;
      end else if (pick < 95) begin
         it.func = cmisp_pkg::FUNC_TICK;
      end
      return it;
   endfunction

   task automatic push_access(input cmisp_pkg::item_type it);
      req_tdata <= {it.cycle_stamp, it.data, it.address};
      req_tuser <= it.func;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_access(it);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic program_settings(input logic [7:0] window, input logic fitted);
      csr_we <= 1'b1;
      csr_index <= cmisp_pkg::CSR_READ_FILTER;
      csr_data <= window;
      @(negedge clock);
      csr_index <= cmisp_pkg::CSR_ROM_PRESENT;
      csr_data <= {7'd0, fitted};
      @(negedge clock);
      csr_we <= 1'b0;
      tracker.set_controls(window, fitted);
      filter_now = window;
   endtask

   // drain responses, stalling at random; hold off for a long stretch on request
   initial begin : response_sink
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = gap_length();
            rsp_tready <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   always @(posedge clock) begin
      cmisp_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.irq_line = rsp_tdata[0];
         got.prg_bank_low = rsp_tdata[6:1];
         got.prg_bank_high = rsp_tdata[12:7];
         got.chr_bank_low = rsp_tdata[18:13];
         got.rom_address = rsp_tdata[50:19];
         got.rom_select = rsp_tuser;
         tracker.check_response(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      cmisp_pkg::item_type directed[$];
      logic [7:0]          windows [PHASES];
      logic                fitted [PHASES];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      stamp_clock = '0;
      filter_now = cmisp_pkg::FILTER_RESET;
      tracker = new();
      windows = '{8'd0, 8'd255, 8'd17, 8'($urandom), 8'd2};
      fitted = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h4800, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hD000, 8'hFF, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hC000, 8'h80, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hCFFF, 8'h7F, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'hCFFF, 8'h00, 32'd2));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h4FFF, 8'h00, 32'd3));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'hC000, 8'h00, 32'd1));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h4800, 8'hFF, 32'hFFFF_FFFF));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h4800, 8'h00, 32'hFFFF_FFFF));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hE000, 8'h3F, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hFFFF, 8'h7F, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hF000, 8'hBF, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hEFFF, 8'hC0, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h5FFF, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h6000, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h9FFF, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'hBFFF, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'hFFFF, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_READ, 16'h47FF, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'h8000, 8'h01, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hB000, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_TICK, 16'h0000, 8'h00, 32'd0));
      directed.push_back(access(cmisp_pkg::FUNC_TICK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));
      directed.push_back(access(cmisp_pkg::FUNC_WRITE, 16'hA000, 8'h00, 32'd0));
      directed.push_back(access(FUNC_SPARE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         push_access(directed[i]);
         idle_sender(gap_length());
      end

      for (int p = 0; p < PHASES; p++) begin
         req_tvalid <= 1'b0;
         while (tracker.expected_q.size() != 0) @(negedge clock);
         program_settings(windows[p], fitted[p]);
         no_idle = (p == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 1 && n == 50) hold_request = 1'b1;
            push_access(random_access());
            idle_sender((no_idle || hold_request) ? 0 : gap_length());
         end
      end

      req_tvalid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
